### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro wraps one concurrent assertion on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QRMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define QRMP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### rtl/qrmp_pkg.sv
// shared types, constants and field widths of the quotient/remainder unit
// no dependencies
package qrmp_pkg;

  localparam int MOD_WIDTH_DEF    = 16;
  localparam int MAX_EXPONENT_DEF = 63;

  localparam int CFG_W   = 16;
  localparam int OPND_W  = 31;
  localparam int QUOT_W  = 63;
  localparam int REM_W   = 16;
  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + OPND_W;
  // dividend high part is already below the modulus, so one step per factor bit
  localparam int DIV_STEPS = OPND_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [QUOT_W-1:0] QMAX = {QUOT_W{1'b1}};

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_POW = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_R,
    S_DIV_LD,
    S_DIV,
    S_MUL_QL,
    S_MUL_QH,
    S_UPD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_R,
    MS_QL,
    MS_QH
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_load;
    logic     div_step;
    logic     p0_load;
    logic     update;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_last;
  } dp_status_t;

endpackage

### rtl/qrmp_ctrl.sv
// sequencer for the quotient/remainder unit: handshakes and step order
// depends on qrmp_pkg
module qrmp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  qrmp_pkg::dp_status_t  status,
  output qrmp_pkg::ctl_cmd_t    cmd
);

  qrmp_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qrmp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qrmp_pkg::S_IDLE:   if (in_valid) state_nxt = qrmp_pkg::S_CHECK;
      qrmp_pkg::S_CHECK:  state_nxt = status.cnt_zero ? qrmp_pkg::S_DONE : qrmp_pkg::S_MUL_R;
      qrmp_pkg::S_MUL_R:  state_nxt = qrmp_pkg::S_DIV_LD;
      qrmp_pkg::S_DIV_LD: state_nxt = qrmp_pkg::S_DIV;
      qrmp_pkg::S_DIV:    if (status.div_last) state_nxt = qrmp_pkg::S_MUL_QL;
      qrmp_pkg::S_MUL_QL: state_nxt = qrmp_pkg::S_MUL_QH;
      qrmp_pkg::S_MUL_QH: state_nxt = qrmp_pkg::S_UPD;
      qrmp_pkg::S_UPD:    state_nxt = qrmp_pkg::S_CHECK;
      qrmp_pkg::S_DONE:   if (out_free) state_nxt = qrmp_pkg::S_IDLE;
      default:            state_nxt = qrmp_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = qrmp_pkg::MS_R;
    in_stall     = 1'b1;
    unique case (state_r)
      qrmp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      qrmp_pkg::S_MUL_R: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrmp_pkg::MS_R;
      end
      qrmp_pkg::S_DIV_LD: cmd.div_load = 1'b1;
      qrmp_pkg::S_DIV:    cmd.div_step = 1'b1;
      qrmp_pkg::S_MUL_QL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrmp_pkg::MS_QL;
      end
      qrmp_pkg::S_MUL_QH: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = qrmp_pkg::MS_QH;
        cmd.p0_load = 1'b1;
      end
      qrmp_pkg::S_UPD:  cmd.update   = 1'b1;
      qrmp_pkg::S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

endmodule

### rtl/qrmp_datapath.sv
// datapath: modulus register, shared multiplier, serial divider, q/r state
// depends on qrmp_pkg; driven by qrmp_ctrl commands
module qrmp_datapath #(
  parameter int MOD_WIDTH    = qrmp_pkg::MOD_WIDTH_DEF,
  parameter int MAX_EXPONENT = qrmp_pkg::MAX_EXPONENT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [qrmp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_operation,
  input  logic [qrmp_pkg::OPND_W-1:0]    in_operand_a,
  input  logic [qrmp_pkg::OPND_W-1:0]    in_operand_b,
  input  qrmp_pkg::ctl_cmd_t             cmd,
  output qrmp_pkg::dp_status_t           status,
  output logic [qrmp_pkg::QUOT_W-1:0]    out_quotient,
  output logic [qrmp_pkg::REM_W-1:0]     out_remainder,
  output logic                           out_overflow
);

  localparam int CNT_W = $clog2(MAX_EXPONENT + 1);
  localparam int OW    = qrmp_pkg::OPND_W;
  localparam int QW    = qrmp_pkg::QUOT_W;
  localparam int AW    = qrmp_pkg::MUL_A_W;

  // modulus, zero stored as one
  logic [MOD_WIDTH-1:0]                 mod_r;
  logic [MOD_WIDTH+qrmp_pkg::CFG_W-1:0] cfg_ext;
  logic [MOD_WIDTH-1:0]                 mod_raw;

  assign cfg_ext = {{MOD_WIDTH{1'b0}}, cfg_wdata};
  assign mod_raw = cfg_ext[MOD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_WIDTH'(1);
    end else if (cfg_we) begin
      mod_r <= (mod_raw == '0) ? MOD_WIDTH'(1) : mod_raw;
    end
  end

  // item state
  logic                  op_r;
  logic [OW-1:0]         f_r, b_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [QW-1:0]         q_r, q_nxt;
  logic [MOD_WIDTH-1:0]  r_r;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      exp_clamped;

  assign exp_clamped = (in_operand_b > OW'(MAX_EXPONENT)) ? CNT_W'(MAX_EXPONENT)
                                                          : in_operand_b[CNT_W-1:0];

  // shared multiplier, registered product
  logic [AW-1:0]                 mul_a;
  logic [qrmp_pkg::PROD_W-1:0]   prod_r;
  logic [MOD_WIDTH+AW-1:0]       r_ext;

  assign r_ext = {{AW{1'b0}}, r_r};

  always_comb begin
    unique case (cmd.mul_sel)
      qrmp_pkg::MS_R:  mul_a = r_ext[AW-1:0];
      qrmp_pkg::MS_QL: mul_a = q_r[AW-1:0];
      qrmp_pkg::MS_QH: mul_a = {1'b0, q_r[QW-1:AW]};
      default:         mul_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_a * f_r;
  end

  // restoring divider, quotient bits shift into the low dividend bits
  logic [MOD_WIDTH-1:0]       rem_r, rem_nxt;
  logic [OW-1:0]              div_lo_r;
  logic [qrmp_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [MOD_WIDTH:0]         trial, diff, mod_ext;
  logic                       ge;

  assign trial   = {rem_r, div_lo_r[OW-1]};
  assign mod_ext = {1'b0, mod_r};
  assign ge      = trial >= mod_ext;
  assign diff    = trial - mod_ext;
  assign rem_nxt = ge ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_load) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r    <= prod_r[MOD_WIDTH+OW-1:OW];
      div_lo_r <= prod_r[OW-1:0];
    end else if (cmd.div_step) begin
      rem_r    <= rem_nxt;
      div_lo_r <= {div_lo_r[OW-2:0], ge};
    end
  end

  assign status.div_last = (div_cnt_r == qrmp_pkg::DIV_CNT_W'(qrmp_pkg::DIV_STEPS - 1));
  assign status.cnt_zero = (cnt_r == '0);

  // q * f + carry from two partial products
  logic [AW+OW:0] p0_r;
  logic [QW+1:0]  sum;
  logic           step_ovf;

  always_ff @(posedge clk) begin
    if (cmd.p0_load) p0_r <= {1'b0, prod_r} + {{(AW + 1){1'b0}}, div_lo_r};
  end

  assign sum      = {2'b00, prod_r[OW-1:0], {AW{1'b0}}} + {1'b0, p0_r};
  assign step_ovf = (|prod_r[2*OW-1:OW]) || sum[QW+1] || sum[QW];

  always_comb begin
    q_nxt   = q_r;
    ovf_nxt = ovf_r;
    if (!ovf_r) begin
      if (step_ovf) begin
        q_nxt   = qrmp_pkg::QMAX;
        ovf_nxt = 1'b1;
      end else begin
        q_nxt = sum[QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= (in_operation == qrmp_pkg::OP_MUL) ? CNT_W'(2) : exp_clamped;
    end else if (cmd.update) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      f_r   <= in_operand_a;
      b_r   <= in_operand_b;
      q_r   <= (mod_r == MOD_WIDTH'(1)) ? QW'(1) : '0;
      r_r   <= (mod_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
      ovf_r <= 1'b0;
    end else if (cmd.update) begin
      q_r   <= q_nxt;
      r_r   <= rem_r;
      ovf_r <= ovf_nxt;
      // second factor of a multiply
      if (op_r == qrmp_pkg::OP_MUL) f_r <= b_r;
    end
  end

  // output register
  logic [MOD_WIDTH+qrmp_pkg::REM_W-1:0] rem_out_ext;
  assign rem_out_ext = {{qrmp_pkg::REM_W{1'b0}}, r_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_quotient  <= q_r;
      out_remainder <= rem_out_ext[qrmp_pkg::REM_W-1:0];
      out_overflow  <= ovf_r;
    end
  end

endmodule

### rtl/quotient_remainder_multiply_power_core.sv
// top level of the quotient/remainder multiply and power unit
// depends on qrmp_pkg, qrmp_ctrl and qrmp_datapath
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_operation, in_operand_a, in_operand_b
//   out      output     out_valid/out_stall out_quotient, out_remainder, out_overflow
//   cfg      input      cfg_we              cfg_wdata (modulus)
//
// one item at a time; every factor step is one multiply of the
// remainder, a one-bit-per-cycle divider over 31 steps, two partial products
// of the quotient through the same 32x31 multiplier, and the update;
// a multiply runs one factor step per operand, a power one factor step per
// exponent, with the exponent clamped to MAX_EXPONENT
// synchronous reset clears the sequencer, the result valid and sets modulus 1
// a finished result waits in the output register while the next item is taken
module quotient_remainder_multiply_power_core #(
  parameter int MOD_WIDTH    = qrmp_pkg::MOD_WIDTH_DEF,
  parameter int MAX_EXPONENT = qrmp_pkg::MAX_EXPONENT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [qrmp_pkg::CFG_W-1:0]   cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_operation,
  input  logic [qrmp_pkg::OPND_W-1:0]  in_operand_a,
  input  logic [qrmp_pkg::OPND_W-1:0]  in_operand_b,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [qrmp_pkg::QUOT_W-1:0]  out_quotient,
  output logic [qrmp_pkg::REM_W-1:0]   out_remainder,
  output logic                         out_overflow
);

  // command and status between sequencer and datapath
  qrmp_pkg::ctl_cmd_t   cmd;
  qrmp_pkg::dp_status_t status;

  // sequencer owns both handshakes and the step order
  qrmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the modulus, the running q/r value and the output register
  qrmp_datapath #(
    .MOD_WIDTH    (MOD_WIDTH),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_operation  (in_operation),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .cmd           (cmd),
    .status        (status),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder),
    .out_overflow  (out_overflow)
  );

endmodule

### rtl/qrmp_checker.sv
// port-level checks for the quotient/remainder unit, bound to the top level
// depends on qrmp_pkg and assert_macros.svh
`include "assert_macros.svh"

module qrmp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [qrmp_pkg::QUOT_W-1:0]  out_quotient,
  input logic [qrmp_pkg::REM_W-1:0]   out_remainder,
  input logic                         out_overflow
);

  // a stalled result keeps its payload
  `QRMP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_quotient) && $stable(out_remainder) && $stable(out_overflow))

  // overflow always comes with a saturated quotient
  `QRMP_ASSERT(a_ovf_sat, out_valid && out_overflow |-> out_quotient == qrmp_pkg::QMAX)

  // remainder stays below the largest modulus
  `QRMP_ASSERT(a_rem_range, out_valid |-> out_remainder != {qrmp_pkg::REM_W{1'b1}})

  // one item at a time: no transfer right after a transfer
  `QRMP_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall)

  // reset drops the result valid
  `QRMP_ASSERT_ALWAYS(a_rst_valid, !rst_n |=> !out_valid)

endmodule

bind quotient_remainder_multiply_power_core qrmp_checker u_qrmp_checker (.*);

### test/tb.sv
// self-checking bench for quotient_remainder_multiply_power_core
// depends on qrmp_pkg and the core rtl; predicts each result transfer from the
// modulus and operands, then compares quotient, remainder and overflow in order
module tb;

  localparam int OPND_W = qrmp_pkg::OPND_W;
  localparam int QUOT_W = qrmp_pkg::QUOT_W;
  localparam int REM_W  = qrmp_pkg::REM_W;
  localparam int CFG_W  = qrmp_pkg::CFG_W;

  // one input transfer
  typedef struct {
    logic              op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
  } qr_job_t;

  // one result transfer
  typedef struct {
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
    logic              ovf;
  } qr_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_operation = qrmp_pkg::OP_MUL;
  logic [OPND_W-1:0] in_operand_a = '0;
  logic [OPND_W-1:0] in_operand_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [QUOT_W-1:0] out_quotient;
  logic [REM_W-1:0]  out_remainder;
  logic              out_overflow;

  // jobs waiting for the driver, results waiting for the dut
  qr_job_t     pending_jobs[$];
  qr_result_t  expected_qr[$];

  // bench copy of the modulus register, reset value 1
  logic [CFG_W-1:0] modulus_copy = 16'd1;

  // idle control: percent chance to start a burst, and burst countdowns
  int          in_gap_pct = 0;
  int          out_stall_pct = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  // input transfer seen at the last rising edge
  logic        in_taken = 1'b0;

  int          fail_count = 0;
  int          queued_count = 0;
  int          checked_count = 0;

  always #6 clk = ~clk;

  quotient_remainder_multiply_power_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quotient  (out_quotient),
    .out_remainder (out_remainder),
    .out_overflow  (out_overflow)
  );

  // quotient/remainder of a*b or a^min(b, max exponent), one factor at a time;
  // the remainder stays exact, the quotient saturates once it leaves 63 bits
  function automatic qr_result_t qr_of_product_or_power(qr_job_t job,
                                                        logic [CFG_W-1:0] mod_reg);
    logic [63:0]  m;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [63:0]  f;
    logic [63:0]  part;
    logic [63:0]  carry;
    logic [127:0] next_q;
    logic         ovf;
    int unsigned  steps;
    int unsigned  i;
    qr_result_t   res;
    // a zero modulus register acts as modulus one
    m = (mod_reg == '0) ? 64'd1 : 64'(mod_reg);
    // the number one split by m
    q = (m == 64'd1) ? 64'd1 : 64'd0;
    r = (m == 64'd1) ? 64'd0 : 64'd1;
    ovf = 1'b0;
    if (job.op == qrmp_pkg::OP_MUL)
      steps = 2;
    else if (job.b > qrmp_pkg::MAX_EXPONENT_DEF)
      steps = qrmp_pkg::MAX_EXPONENT_DEF;   // large exponents clamp
    else
      steps = 32'(job.b);                   // exponent zero leaves the value one
    for (i = 0; i < steps; i++) begin
      f = (job.op == qrmp_pkg::OP_MUL && i == 1) ? 64'(job.b) : 64'(job.a);
      part = r * f;
      carry = part / m;
      r = part % m;
      if (!ovf) begin
        next_q = 128'(q) * 128'(f) + 128'(carry);
        if (next_q > 128'(qrmp_pkg::QMAX)) begin
          ovf = 1'b1;
          q = 64'(qrmp_pkg::QMAX);
        end else begin
          q = next_q[63:0];
        end
      end
    end
    res.quot = q[QUOT_W-1:0];
    res.rem  = r[REM_W-1:0];
    res.ovf  = ovf;
    return res;
  endfunction

  // operand picker biased toward edges and values near the modulus
  function automatic logic [OPND_W-1:0] pick_operand(logic [CFG_W-1:0] mod_reg);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OPND_W'(1);
      2: return '1;
      3: return OPND_W'(mod_reg) + OPND_W'($urandom_range(0, 2)) - OPND_W'(1);
      4: return OPND_W'($urandom_range(0, 255));
      5: return OPND_W'($urandom_range(0, 65535));
      default: return OPND_W'($urandom);
    endcase
  endfunction

  task automatic push_job(input logic op, input logic [OPND_W-1:0] a,
                          input logic [OPND_W-1:0] b);
    qr_job_t job;
    job.op = op;
    job.a  = a;
    job.b  = b;
    pending_jobs.push_back(job);
    queued_count++;
  endtask

  // sender holds off until every queued job has produced its result
  task automatic drain();
    while (checked_count != queued_count) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only issued while the dut is idle
  task automatic write_modulus(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // rising edge: track register writes, predict accepted jobs, check results
  always @(posedge clk) begin : monitor
    qr_job_t    job;
    qr_result_t want;
    if (!rst_n) begin
      in_taken     <= 1'b0;
      modulus_copy <= 16'd1;
    end else begin
      if (cfg_we)
        modulus_copy <= cfg_wdata;
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        job.op = in_operation;
        job.a  = in_operand_a;
        job.b  = in_operand_b;
        expected_qr.push_back(qr_of_product_or_power(job, modulus_copy));
      end
      if (out_valid && !out_stall) begin
        if (expected_qr.size() == 0) begin
          $error("result transfer with nothing expected: quotient %0d remainder %0d",
                 out_quotient, out_remainder);
          fail_count++;
        end else begin
          want = expected_qr.pop_front();
          checked_count++;
          if (out_quotient !== want.quot) begin
            $error("quotient mismatch: expected %0d, actual %0d", want.quot, out_quotient);
            fail_count++;
          end
          if (out_remainder !== want.rem) begin
            $error("remainder mismatch: expected %0d, actual %0d", want.rem, out_remainder);
            fail_count++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow mismatch: expected %0d, actual %0d", want.ovf, out_overflow);
            fail_count++;
          end
        end
      end
    end
  end

  // falling edge: feed jobs with random gaps, stall the result side in bursts
  always @(negedge clk) begin : driver
    qr_job_t job;
    // a stalled transfer keeps valid and payload as they are
    if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_jobs.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
        // start a gap with a random countdown from 0 to 16
        in_gap   = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pending_jobs.size() != 0) begin
        job = pending_jobs.pop_front();
        in_valid     <= 1'b1;
        in_operation <= job.op;
        in_operand_a <= job.a;
        in_operand_b <= job.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (out_hold > 0) begin
      out_hold--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      out_hold  = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int unsigned      p;
    int unsigned      n;
    logic             op;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [CFG_W-1:0] mod_val;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, modulus still at its reset value of one
    push_job(qrmp_pkg::OP_MUL, '1, '1);             // largest product
    push_job(qrmp_pkg::OP_MUL, '0, '1);
    push_job(qrmp_pkg::OP_POW, '0, '0);             // zero to the zero gives one
    push_job(qrmp_pkg::OP_POW, '1, '0);
    push_job(qrmp_pkg::OP_POW, OPND_W'(2), OPND_W'(62));
    push_job(qrmp_pkg::OP_POW, OPND_W'(2), OPND_W'(63));  // just past the quotient range
    push_job(qrmp_pkg::OP_POW, OPND_W'(3), '1);     // clamped exponent, overflow
    push_job(qrmp_pkg::OP_POW, OPND_W'(1), OPND_W'(64));
    push_job(qrmp_pkg::OP_POW, '0, OPND_W'(7));
    drain();

    // zero register behaves as modulus one
    write_modulus(16'd0);
    push_job(qrmp_pkg::OP_MUL, OPND_W'(12345), OPND_W'(678));
    push_job(qrmp_pkg::OP_POW, OPND_W'(2), OPND_W'(63));
    drain();

    // widest modulus: overflow with exact remainder, and a near miss
    write_modulus(16'hFFFF);
    push_job(qrmp_pkg::OP_MUL, '1, '1);
    push_job(qrmp_pkg::OP_POW, '1, OPND_W'(63));
    push_job(qrmp_pkg::OP_POW, OPND_W'(2), OPND_W'(63));
    push_job(qrmp_pkg::OP_POW, OPND_W'(65535), OPND_W'(3));
    push_job(qrmp_pkg::OP_POW, OPND_W'(65534), OPND_W'(2));
    drain();

    write_modulus(16'd2);
    push_job(qrmp_pkg::OP_POW, OPND_W'(3), OPND_W'(40));
    push_job(qrmp_pkg::OP_MUL, OPND_W'(1), OPND_W'(1));
    push_job(qrmp_pkg::OP_POW, OPND_W'(2), OPND_W'(64));
    drain();

    // random phases, one modulus each; phases 2 and 7 run without idling
    for (p = 0; p < 8; p++) begin
      case (p)
        0: mod_val = 16'hFFFF;
        1: mod_val = 16'd1;
        2: mod_val = 16'd0;
        3: mod_val = 16'd3;
        4: mod_val = 16'h8000;
        default: mod_val = CFG_W'($urandom);
      endcase
      write_modulus(mod_val);
      if (p == 2 || p == 7) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(5, 40);
        out_stall_pct = $urandom_range(2, 20);
      end
      for (n = 0; n < 104; n++) begin
        op = ($urandom_range(0, 1) != 0) ? qrmp_pkg::OP_POW : qrmp_pkg::OP_MUL;
        a  = pick_operand(mod_val);
        if (op == qrmp_pkg::OP_MUL) begin
          b = pick_operand(mod_val);
        end else begin
          // mostly short exponents to keep the run short, some long or clamped
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: b = OPND_W'($urandom_range(0, 10));
            6, 7:             b = OPND_W'($urandom_range(11, 63));
            8:                b = OPND_W'($urandom_range(64, 32'h7FFF_FFFF));
            default:          b = OPND_W'($urandom_range(62, 65));
          endcase
        end
        push_job(op, a, b);
      end
      drain();
    end

    // quiet tail to catch any stray result
    repeat (300) @(negedge clk);
    if (expected_qr.size() != 0) begin
      $error("%0d expected results never arrived", expected_qr.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // ends the run as failed if the stimulus never finishes
  initial begin : watchdog
    #120000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
